FILE: hw/rtl/png_stored_deflate_encoder_unit_defines.svh
// assertion macros for the png stored deflate encoder
`ifndef PNG_STORED_DEFLATE_ENCODER_UNIT_DEFINES_SVH
`define PNG_STORED_DEFLATE_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSDE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define PSDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/psde_pkg.sv
// shared constants and helper functions of the png stored deflate encoder
package psde_pkg;

    localparam int unsigned DIM_W    = 14;
    localparam int unsigned RAW_W    = 30;
    localparam int unsigned IDX_W    = 6;
    // block count uses a fold by 2^16-1, so the block size is fixed
    localparam int unsigned STORED_BLOCK_MAX = 65535;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  PNG_SIG0 = 8'd137;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // header bytes up to the zlib header; variable fields read as zero
    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            6'd0:    b = PNG_SIG0;
            6'd1:    b = 8'h50;
            6'd2:    b = 8'h4E;
            6'd3:    b = 8'h47;
            6'd4:    b = 8'h0D;
            6'd5:    b = 8'h0A;
            6'd6:    b = 8'h1A;
            6'd7:    b = 8'h0A;
            6'd11:   b = 8'd13;
            6'd12:   b = 8'h49;
            6'd13:   b = 8'h48;
            6'd14:   b = 8'h44;
            6'd15:   b = 8'h52;
            6'd24:   b = 8'd8;
            6'd25:   b = 8'd2;
            6'd37:   b = 8'h49;
            6'd38:   b = 8'h44;
            6'd39:   b = 8'h41;
            6'd40:   b = 8'h54;
            6'd41:   b = 8'h78;
            6'd42:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // trailer constant bytes (iend length and type)
    function automatic logic [7:0] trl_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            6'd12:   b = 8'h49;
            6'd13:   b = 8'h45;
            6'd14:   b = 8'h4E;
            6'd15:   b = 8'h44;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/png_stored_deflate_encoder_unit.sv
// png stream encoder with stored deflate blocks, top level
//
// Takes RGB image bytes in raster order and sends out a complete PNG file. Each image byte
// adds one output byte; the first byte of a file adds 43 bytes before it (signature, IHDR,
// IDAT length and type, zlib header), each row adds one filter byte, each stored block adds
// five bytes for BFINAL/LEN/NLEN, and the last byte adds 20 bytes after it (Adler-32, IDAT
// CRC, IEND). The output port sets the pace: one byte leaves per cycle while i_m_tready is
// high and an input byte is held. The stored block count for the IDAT length is folded
// from the registered raw length, long before the length bytes go out. Width and height
// writes are taken only between files.
module png_stored_deflate_encoder_unit #(
    parameter int unsigned MAX_DIMENSION    = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [13:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // pixel_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tlast,   // run_last
    output logic        o_m_tuser    // file_end
);

    localparam int unsigned RAW_W = psde_pkg::RAW_W;
    localparam int unsigned DIM_W = psde_pkg::DIM_W;
    localparam int unsigned IDX_W = psde_pkg::IDX_W;
    localparam int unsigned BLK_W = $clog2(psde_pkg::STORED_BLOCK_MAX + 1);
    localparam logic [RAW_W-1:0] BLK_MAX_RAW = RAW_W'(psde_pkg::STORED_BLOCK_MAX);
    localparam logic [RAW_W-1:0] BLK_RND     = RAW_W'(psde_pkg::STORED_BLOCK_MAX - 1);
    localparam logic [15:0]      DIM_MAX     = 16'(MAX_DIMENSION);

    typedef enum logic [1:0] {P_HDR, P_BH, P_RAW, P_TRL} t_phase;

    logic [DIM_W-1:0] r_width, r_height;
    logic [31:0]      r_crc, r_hold;
    logic [15:0]      r_adl_lo, r_adl_hi;
    logic [15:0]      r_col, r_row_len;
    logic [DIM_W-1:0] r_row;
    logic [BLK_W-1:0] r_blk;
    logic [RAW_W-1:0] r_raw_left, r_raw;
    logic             r_hs;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_fresh;
    t_phase           r_phase;
    logic [IDX_W-1:0] r_idx;
    logic             r_filt;
    logic             r_out_valid, r_out_last, r_out_end;
    logic [7:0]       r_out_data;
    logic [15:0]      r_blocks;

    t_phase           e_phase, n_phase;
    logic [IDX_W-1:0] e_idx, n_idx;
    logic             e_filt, n_filt;
    logic             adv, done, fin;
    logic [7:0]       byte_out;
    logic [BLK_W-1:0] blk_n, blk_eff, n_blk;
    logic [15:0]      len16, inv16;
    logic             bfinal;
    logic [31:0]      crc_fin, idat_len, crc_in;
    logic             crc_start, hold_load;
    logic [16:0]      sum_lo, lo2, sum_hi, hi2;
    logic [15:0]      col_inc, row_plus, row_len3;
    logic [RAW_W-1:0] raw_calc;
    logic [RAW_W-1:0] rnd_raw;
    logic [16:0]      fold_sum;
    logic [15:0]      blk_cnt;
    logic [15:0]      cfg_ext;
    logic [DIM_W-1:0] cfg_val;

    assign adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign crc_fin  = ~r_crc;
    assign idat_len = 32'd6 + 32'(r_raw) + 32'(r_blocks) + (32'(r_blocks) << 2);
    assign row_plus = {2'b00, r_width} + {1'b0, r_width, 1'b0} + 16'd1;
    assign row_len3 = row_plus - 16'd1;
    assign raw_calc = RAW_W'({16'h0, r_height} * {14'h0, row_plus});
    // ceil(raw / (2^16-1)): x = a*2^16 + b gives a plus one when a + b reaches 2^16-1
    assign rnd_raw  = r_raw + BLK_RND;
    assign fold_sum = {1'b0, rnd_raw[15:0]} + 17'(rnd_raw[RAW_W-1:16]);
    assign blk_cnt  = 16'(rnd_raw[RAW_W-1:16]) + 16'(fold_sum >= 17'd65535);
    assign blk_n    = (r_raw_left < BLK_MAX_RAW) ? r_raw_left[BLK_W-1:0] : BLK_MAX_RAW[BLK_W-1:0];
    assign bfinal   = (r_raw_left <= BLK_MAX_RAW);
    assign len16    = 16'(blk_n);
    assign inv16    = ~len16;
    assign blk_eff  = (r_blk == '0) ? blk_n : r_blk;
    assign n_blk    = (blk_eff != '0) ? blk_eff - BLK_W'(1) : '0;
    assign col_inc  = r_col + 16'd1;
    assign sum_lo   = {1'b0, r_adl_lo} + {9'h0, byte_out};
    assign lo2      = (sum_lo >= psde_pkg::ADLER_MOD) ? sum_lo - psde_pkg::ADLER_MOD : sum_lo;
    assign sum_hi   = {1'b0, r_adl_hi} + lo2;
    assign hi2      = (sum_hi >= psde_pkg::ADLER_MOD) ? sum_hi - psde_pkg::ADLER_MOD : sum_hi;
    assign cfg_ext  = {2'b00, i_cfg_data};
    assign cfg_val  = (i_cfg_data == '0) ? DIM_W'(1) :
                      (cfg_ext > DIM_MAX) ? DIM_MAX[DIM_W-1:0] : i_cfg_data;

    // phase of the byte about to go out
    always_comb begin
        if (r_fresh) begin
            e_idx = '0;
            if (!r_hs) begin
                e_phase = P_HDR;
                e_filt  = 1'b1;
            end else begin
                e_filt  = (r_col == '0);
                e_phase = (r_blk == '0) ? P_BH : P_RAW;
            end
        end else begin
            e_phase = r_phase;
            e_idx   = r_idx;
            e_filt  = r_filt;
        end
    end

    always_comb begin
        unique case (e_phase)
            P_HDR: begin
                unique case (e_idx)
                    6'd18:   byte_out = {2'b00, r_width[13:8]};
                    6'd19:   byte_out = r_width[7:0];
                    6'd22:   byte_out = {2'b00, r_height[13:8]};
                    6'd23:   byte_out = r_height[7:0];
                    6'd29:   byte_out = crc_fin[31:24];
                    6'd30:   byte_out = r_hold[23:16];
                    6'd31:   byte_out = r_hold[15:8];
                    6'd32:   byte_out = r_hold[7:0];
                    6'd33:   byte_out = idat_len[31:24];
                    6'd34:   byte_out = idat_len[23:16];
                    6'd35:   byte_out = idat_len[15:8];
                    6'd36:   byte_out = idat_len[7:0];
                    default: byte_out = psde_pkg::hdr_byte(e_idx);
                endcase
            end
            P_BH: begin
                unique case (e_idx)
                    6'd0:    byte_out = {7'h0, bfinal};
                    6'd1:    byte_out = len16[7:0];
                    6'd2:    byte_out = len16[15:8];
                    6'd3:    byte_out = inv16[7:0];
                    default: byte_out = inv16[15:8];
                endcase
            end
            P_RAW: byte_out = e_filt ? 8'h00 : r_in_byte;
            P_TRL: begin
                unique case (e_idx)
                    6'd0:    byte_out = r_adl_hi[15:8];
                    6'd1:    byte_out = r_adl_hi[7:0];
                    6'd2:    byte_out = r_adl_lo[15:8];
                    6'd3:    byte_out = r_adl_lo[7:0];
                    6'd4:    byte_out = crc_fin[31:24];
                    6'd5:    byte_out = r_hold[23:16];
                    6'd6:    byte_out = r_hold[15:8];
                    6'd7:    byte_out = r_hold[7:0];
                    6'd16:   byte_out = crc_fin[31:24];
                    6'd17:   byte_out = r_hold[23:16];
                    6'd18:   byte_out = r_hold[15:8];
                    6'd19:   byte_out = r_hold[7:0];
                    default: byte_out = psde_pkg::trl_byte(e_idx);
                endcase
            end
            default: byte_out = 8'h00;
        endcase
    end

    assign crc_start = (e_phase == P_HDR && (e_idx == 6'd12 || e_idx == 6'd37)) ||
                       (e_phase == P_TRL && e_idx == 6'd12);
    assign hold_load = (e_phase == P_HDR && e_idx == 6'd29) ||
                       (e_phase == P_TRL && (e_idx == 6'd4 || e_idx == 6'd16));
    assign crc_in    = crc_start ? 32'hFFFFFFFF : r_crc;

    // sequencing of the bytes of one input item
    always_comb begin
        n_phase = e_phase;
        n_idx   = e_idx + IDX_W'(1);
        n_filt  = e_filt;
        done    = 1'b0;
        fin     = 1'b0;
        unique case (e_phase)
            P_HDR: begin
                if (e_idx == 6'd42) begin
                    n_phase = P_BH;
                    n_idx   = '0;
                    n_filt  = 1'b1;
                end
            end
            P_BH: begin
                if (e_idx == 6'd4) begin
                    n_phase = P_RAW;
                    n_idx   = '0;
                end
            end
            P_RAW: begin
                n_idx = '0;
                if (e_filt) begin
                    n_filt  = 1'b0;
                    n_phase = (n_blk == '0) ? P_BH : P_RAW;
                end else if (col_inc == r_row_len &&
                             ({2'b00, r_row} + 16'd1) == {2'b00, r_height}) begin
                    n_phase = P_TRL;
                end else begin
                    done = 1'b1;
                end
            end
            P_TRL: begin
                if (e_idx == 6'd19) begin
                    done = 1'b1;
                    fin  = 1'b1;
                end
            end
            default: done = 1'b1;
        endcase
    end

    assign o_s_tready = !r_in_valid || (adv && done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_W'(1);
            r_height    <= DIM_W'(1);
            r_crc       <= 32'hFFFFFFFF;
            r_adl_lo    <= 16'd1;
            r_adl_hi    <= 16'd0;
            r_col       <= '0;
            r_row       <= '0;
            r_blk       <= '0;
            r_raw_left  <= '0;
            r_hs        <= 1'b0;
            r_in_valid  <= 1'b0;
            r_fresh     <= 1'b1;
            r_phase     <= P_HDR;
            r_idx       <= '0;
            r_filt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && !r_hs) begin
                unique case (i_cfg_idx)
                    psde_pkg::CFG_WIDTH:  r_width  <= cfg_val;
                    psde_pkg::CFG_HEIGHT: r_height <= cfg_val;
                    default: ;
                endcase
            end

            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
                r_crc       <= psde_pkg::crc_byte(crc_in, byte_out);
                r_fresh     <= done;
                r_phase     <= n_phase;
                r_idx       <= n_idx;
                r_filt      <= n_filt;
                if (hold_load) begin
                    r_hold <= crc_fin;
                end
                if (e_phase == P_HDR && e_idx == '0) begin
                    r_hs       <= 1'b1;
                    r_raw      <= raw_calc;
                    r_raw_left <= raw_calc;
                    r_row_len  <= row_len3;
                    r_blk      <= '0;
                    r_col      <= '0;
                    r_row      <= '0;
                    r_adl_lo   <= 16'd1;
                    r_adl_hi   <= 16'd0;
                end
                if (e_phase == P_RAW) begin
                    r_adl_lo <= lo2[15:0];
                    r_adl_hi <= hi2[15:0];
                    r_blk    <= n_blk;
                    if (r_raw_left != '0) begin
                        r_raw_left <= r_raw_left - RAW_W'(1);
                    end
                    if (!e_filt) begin
                        if (col_inc == r_row_len) begin
                            r_col <= '0;
                            r_row <= r_row + DIM_W'(1);
                        end else begin
                            r_col <= col_inc;
                        end
                    end
                end
                if (fin) begin
                    r_hs       <= 1'b0;
                    r_col      <= '0;
                    r_row      <= '0;
                    r_blk      <= '0;
                    r_raw_left <= '0;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (adv) begin
            r_out_data <= byte_out;
            r_out_last <= done;
            r_out_end  <= fin;
        end
        r_blocks <= blk_cnt;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;

endmodule

FILE: hw/rtl/psde_checker.sv
// port checker for the png stored deflate encoder, bound to the top level
`include "png_stored_deflate_encoder_unit_defines.svh"

module psde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    // file end always closes the run of its item
    `PSDE_ASSERT_NOW(a_end_is_last, o_m_tvalid && o_m_tuser, o_m_tlast)

    // stalled output holds
    `PSDE_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))

    // the byte after a file end opens a new signature
    `PSDE_ASSERT_NEXT(a_sig_after_end, o_m_tvalid && i_m_tready && o_m_tuser, !o_m_tvalid || o_m_tdata == psde_pkg::PNG_SIG0)

endmodule

bind png_stored_deflate_encoder_unit psde_checker u_psde_checker (.*);

FILE: tb/sv/tb.sv
// testbench for the png stored deflate encoder: byte stream prediction and checking
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fend;
} t_png_byte;

class png_stream_scoreboard;
    int unsigned width_px = 1;
    int unsigned height_rows = 1;
    bit [31:0] crc;
    bit [31:0] adler_lo;
    bit [31:0] adler_hi;
    int unsigned col;
    int unsigned row;
    int unsigned blk_left;
    int unsigned raw_left;
    bit file_open;
    t_png_byte expected_q[$];
    t_png_byte step_q[$];
    int errors;
    int checked;
    int files_done;

    function new();
        crc = 32'hFFFF_FFFF;
        adler_lo = 1;
        adler_hi = 0;
    endfunction

    function void push_byte(bit [7:0] b);
        bit [31:0] c;
        t_png_byte t;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (32'hEDB8_8320 ^ (c >> 1)) : (c >> 1);
        end
        crc = c;
        t = '{b, 1'b0, 1'b0};
        step_q = {step_q, t};
    endfunction

    function void push_be32(bit [31:0] v);
        push_byte(v[31:24]);
        push_byte(v[23:16]);
        push_byte(v[15:8]);
        push_byte(v[7:0]);
    endfunction

    function void push_tag(bit [31:0] tag);
        crc = 32'hFFFF_FFFF;
        push_be32(tag);
    endfunction

    function void push_raw(bit [7:0] b);
        bit [15:0] n;
        if (blk_left == 0) begin
            n = (raw_left < 65535) ? raw_left[15:0] : 16'hFFFF;
            push_byte((raw_left <= 65535) ? 8'd1 : 8'd0);
            push_byte(n[7:0]);
            push_byte(n[15:8]);
            push_byte(~n[7:0]);
            push_byte(~n[15:8]);
            blk_left = 32'(n);
        end
        push_byte(b);
        adler_lo += b;
        if (adler_lo >= 65521) adler_lo -= 65521;
        adler_hi += adler_lo;
        if (adler_hi >= 65521) adler_hi -= 65521;
        if (blk_left != 0) blk_left--;
        if (raw_left != 0) raw_left--;
    endfunction

    function void start_file();
        int unsigned raw_len;
        int unsigned blocks;
        raw_len = height_rows * (3 * width_px + 1);
        blocks = (raw_len + 65534) / 65535;
        push_be32(32'h8950_4E47);
        push_be32(32'h0D0A_1A0A);
        push_be32(32'd13);
        push_tag("IHDR");
        push_be32(width_px);
        push_be32(height_rows);
        push_byte(8'd8);
        push_byte(8'd2);
        push_byte(8'd0);
        push_byte(8'd0);
        push_byte(8'd0);
        push_be32(~crc);
        push_be32(2 + raw_len + 5 * blocks + 4);
        push_tag("IDAT");
        push_byte(8'h78);
        push_byte(8'h01);
        raw_left = raw_len;
        blk_left = 0;
        col = 0;
        row = 0;
        adler_lo = 1;
        adler_hi = 0;
        file_open = 1;
    endfunction

    function void finish_file();
        t_png_byte t;
        push_be32({adler_hi[15:0], adler_lo[15:0]});
        push_be32(~crc);
        push_be32(32'd0);
        push_tag("IEND");
        push_be32(~crc);
        t = step_q.pop_back();
        t.fend = 1'b1;
        step_q = {step_q, t};
        file_open = 0;
        col = 0;
        row = 0;
        blk_left = 0;
        raw_left = 0;
        files_done++;
    endfunction

    function void note_input(bit [7:0] b);
        t_png_byte t;
        step_q.delete();
        if (!file_open) start_file();
        if (col == 0) push_raw(8'h00);
        push_raw(b);
        col++;
        if (col >= 3 * width_px) begin
            col = 0;
            row++;
            if (row >= height_rows) finish_file();
        end
        t = step_q.pop_back();
        t.last = 1'b1;
        step_q = {step_q, t};
        expected_q = {expected_q, step_q};
    endfunction

    function void write_reg(bit idx, bit [13:0] value);
        int unsigned v;
        if (file_open) return;
        v = 32'(value);
        if (v < 1) v = 1;
        if (v > 8192) v = 8192;
        if (idx == psde_pkg::CFG_WIDTH) width_px = v;
        else height_rows = v;
    endfunction

    function void check_result(t_png_byte got);
        t_png_byte exp_b;
        checked++;
        if (expected_q.size() == 0) begin
            $error("unexpected output transfer data=%0h", got.data);
            errors++;
            return;
        end
        exp_b = expected_q.pop_front();
        if (got.data !== exp_b.data) begin
            $error("out_byte expected %0h actual %0h", exp_b.data, got.data);
            errors++;
        end
        if (got.last !== exp_b.last) begin
            $error("run_last expected %0b actual %0b", exp_b.last, got.last);
            errors++;
        end
        if (got.fend !== exp_b.fend) begin
            $error("file_end expected %0b actual %0b", exp_b.fend, got.fend);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int LIMIT = 4_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [13:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    png_stream_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int phase_items;
    int unsigned cycles = 0;

    png_stored_deflate_encoder_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // monitor: note accepted input before checking output of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_input(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result({o_m_tdata, o_m_tlast, o_m_tuser});
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        phase_items++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input logic [13:0] w, input logic [13:0] h);
        wait_drained();
        write_reg(psde_pkg::CFG_WIDTH, w);
        write_reg(psde_pkg::CFG_HEIGHT, h);
    endtask

    task automatic send_rest_of_file();
        int n;
        n = 3 * sb.width_px * sb.height_rows;
        if (sb.file_open) n = n - (sb.row * 3 * sb.width_px + sb.col);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_files(input int target);
        phase_items = 0;
        while (phase_items < target) begin
            set_dims(14'($urandom_range(1, 6)), 14'($urandom_range(1, 4)));
            send_rest_of_file();
        end
    endtask

    initial begin
        sb = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= psde_pkg::CFG_WIDTH;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        send_idle_pct = 11;
        recv_idle_pct = 84;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of range writes clamp to one pixel
        write_reg(psde_pkg::CFG_WIDTH, 14'd0);
        write_reg(psde_pkg::CFG_HEIGHT, 14'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h80);
        send_byte(8'h01);
        // second file of two rows, with a write attempt mid-file
        set_dims(14'd1, 14'd2);
        send_byte(8'h7F);
        send_byte(8'hFE);
        wait_drained();
        write_reg(psde_pkg::CFG_WIDTH, 14'd5);
        write_reg(psde_pkg::CFG_HEIGHT, 14'd3);
        send_rest_of_file();
        random_files(40);

        send_idle_pct = 84;
        recv_idle_pct = 11;
        random_files(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_files(40);

        send_idle_pct = 30;
        recv_idle_pct = 30;
        random_files(20);

        wait_drained();
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected bytes never arrived", sb.expected_q.size());
            sb.errors++;
        end
        $display("tb: %0d pixel bytes in, %0d png bytes checked, %0d files completed",
                 items_sent, sb.checked, sb.files_done);
        $display("tb: clamped 1x1 files, a write ignored mid-file, small random images, mixed stalls");
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
